// ----- sv/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants, register indexes and control types of the position
// stall detector.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 10;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_RADIUS_SQ = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEEDED_COUNT   = 2'd2;

	localparam logic [15:0] SAMPLE_PERIOD_RST  = 16'd200;
	localparam logic [31:0] NEAR_RADIUS_SQ_RST = 32'd256;
	localparam logic [3:0]  NEEDED_COUNT_RST   = 4'd10;

	typedef struct packed {
		logic load_in;
		logic decide;
		logic scan_step;
		logic load_out;
	} psd_cmd_t;

	typedef struct packed {
		logic hit;
		logic last_entry;
		logic pipe_busy;
		logic out_free;
	} psd_status_t;

endpackage

// ----- sv/psd_if.sv -----
// ----------------------------------------------------------------------------
// psd_if
// Request channels of the position stall detector: position samples in,
// stall results out.
// ----------------------------------------------------------------------------
interface psd_in_if;
	logic               valid;
	logic               ready;
	logic        [31:0] now_ms;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;

	modport source (output valid, output now_ms, output pos_x, output pos_y, input ready);
	modport sink   (input valid, input now_ms, input pos_x, input pos_y, output ready);
endinterface

interface psd_out_if;
	logic       valid;
	logic       ready;
	logic       blocked;
	logic       sampled;
	logic [3:0] near_count;

	modport source (output valid, output blocked, output sampled, output near_count,
		input ready);
	modport sink   (input valid, input blocked, input sampled, input near_count,
		output ready);
endinterface

// ----- sv/psd_ctrl.sv -----
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer: takes a request, decides on sampling, walks the history
// ring one entry per cycle and hands the result to the output register.
// ----------------------------------------------------------------------------
module psd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  psd_pkg::psd_status_t status,
	output psd_pkg::psd_cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MAG    = 6'b000010,
		ST_DECIDE = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_FINISH = 6'b100000
	} psd_state_t;

	psd_state_t state_q;
	psd_state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = ST_MAG;
				end
			end
			ST_MAG: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = status.hit ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.last_entry) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.load_out = status.out_free;
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/psd_datapath.sv -----
// ----------------------------------------------------------------------------
// psd_datapath
// Configuration registers, elapsed time check, history ring, squared
// distance pipeline, near counter and output register.
// ----------------------------------------------------------------------------
module psd_datapath #(
	parameter int unsigned HISTORY_DEPTH = psd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [psd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [psd_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
	input  logic [31:0]                       now_ms,
	input  logic signed [15:0]                pos_x,
	input  logic signed [15:0]                pos_y,
	input  psd_pkg::psd_cmd_t                 cmd,
	output psd_pkg::psd_status_t              status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              blocked,
	output logic                              sampled,
	output logic [3:0]                        near_count
);

	localparam int unsigned IDXW = $clog2(HISTORY_DEPTH);
	localparam int unsigned CW   = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned CMPW = (CW > 4) ? CW : 4;

	logic [15:0] period_q;
	logic [31:0] radius_q;
	logic [3:0]  needed_q;

	logic [31:0]        now_q;
	logic signed [15:0] px_q;
	logic signed [15:0] py_q;
	logic [31:0]        d_q;
	logic [31:0]        mag_q;
	logic [31:0]        last_time_q;

	logic signed [15:0] hist_x_q [HISTORY_DEPTH];
	logic signed [15:0] hist_y_q [HISTORY_DEPTH];
	logic [IDXW-1:0]    wr_idx_q;
	logic [IDXW-1:0]    rd_idx_q;

	logic               v_s1;
	logic signed [15:0] hx_s1;
	logic signed [15:0] hy_s1;
	logic               v_s2;
	logic [32:0]        sqx_s2;
	logic [32:0]        sqy_s2;

	logic [CW-1:0]      count_q;
	logic               sampled_q;

	logic               out_valid_q;
	logic               blocked_q;
	logic               sampled_out_q;
	logic [3:0]         near_count_q;

	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic signed [33:0] sqx;
	logic signed [33:0] sqy;
	logic [33:0]        dsum;
	logic [31:0]        dsat;
	logic               near;
	logic [CMPW-1:0]    count_ext;
	logic [CMPW-1:0]    needed_ext;
	logic               is_blocked;
	logic               out_free;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= psd_pkg::SAMPLE_PERIOD_RST;
			radius_q <= psd_pkg::NEAR_RADIUS_SQ_RST;
			needed_q <= psd_pkg::NEEDED_COUNT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				psd_pkg::REG_SAMPLE_PERIOD:  period_q <= cfg_wr_data[15:0];
				psd_pkg::REG_NEAR_RADIUS_SQ: radius_q <= cfg_wr_data[31:0];
				psd_pkg::REG_NEEDED_COUNT:   needed_q <= cfg_wr_data[3:0];
				default: ;
			endcase
		end
	end

	// request capture and elapsed magnitude
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_q <= now_ms;
			px_q  <= pos_x;
			py_q  <= pos_y;
			d_q   <= now_ms - last_time_q;
		end
		mag_q <= d_q[31] ? (32'd0 - d_q) : d_q;
	end

	assign status.hit = mag_q > {16'd0, period_q};

	// distance pipeline
	assign dx   = 17'(px_q) - 17'(hx_s1);
	assign dy   = 17'(py_q) - 17'(hy_s1);
	assign sqx  = dx * dx;
	assign sqy  = dy * dy;
	assign dsum = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign dsat = (|dsum[33:32]) ? 32'hFFFF_FFFF : dsum[31:0];
	assign near = dsat < radius_q;

	always_ff @(posedge clk) begin
		hx_s1  <= hist_x_q[rd_idx_q];
		hy_s1  <= hist_y_q[rd_idx_q];
		sqx_s2 <= sqx[32:0];
		sqy_s2 <= sqy[32:0];
	end

	// history ring, pointers and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_x_q[i] <= '0;
				hist_y_q[i] <= '0;
			end
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			count_q     <= '0;
			sampled_q   <= 1'b0;
			last_time_q <= '0;
		end else begin
			v_s1 <= cmd.scan_step;
			v_s2 <= v_s1;
			if (cmd.decide) begin
				sampled_q <= status.hit;
				count_q   <= '0;
				rd_idx_q  <= '0;
				if (status.hit) begin
					hist_x_q[wr_idx_q] <= px_q;
					hist_y_q[wr_idx_q] <= py_q;
					wr_idx_q <= (wr_idx_q == IDXW'(HISTORY_DEPTH - 1)) ? '0
						: wr_idx_q + 1'b1;
				end
			end
			if (cmd.scan_step) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (v_s2 && near) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.load_out && sampled_q && !is_blocked) begin
				last_time_q <= now_q;
			end
		end
	end

	assign status.last_entry = rd_idx_q == IDXW'(HISTORY_DEPTH - 1);
	assign status.pipe_busy  = v_s1 | v_s2;

	// result
	assign count_ext  = CMPW'(count_q);
	assign needed_ext = CMPW'(needed_q);
	assign is_blocked = sampled_q && (count_ext >= needed_ext);
	assign out_free   = !out_valid_q || out_ready;
	assign status.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			blocked_q     <= is_blocked;
			sampled_out_q <= sampled_q;
			if (!sampled_q) begin
				near_count_q <= 4'd0;
			end else if (count_ext > CMPW'(15)) begin
				near_count_q <= 4'd15;
			end else begin
				near_count_q <= count_ext[3:0];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign blocked    = blocked_q;
	assign sampled    = sampled_out_q;
	assign near_count = near_count_q;

endmodule

// ----- sv/position_stall_detector.sv -----
// ----------------------------------------------------------------------------
// position_stall_detector
// Samples timestamped positions into a history ring and reports when
// enough stored positions lie near the current one.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid / ready      now_ms[31:0], pos_x[15:0] s, pos_y[15:0] s
//  out_ch    out  valid / ready      blocked, sampled, near_count[3:0]
//  cfg       in   cfg_wr_en          cfg_index[1:0], cfg_wr_data[31:0]
//
//  a request that is not sampled passes from accept through the MAG, DECIDE
//  and FINISH states to the result; a sampled request also runs the history
//  scan and DRAIN: one ring entry per cycle through the s1 and s2 distance pipe
//  one request at a time; in_ch.ready is high only while idle
//  the result register holds while out_ch stalls; the next request is taken
//  the history ring clears at reset, with no clearing pass
// ----------------------------------------------------------------------------
module position_stall_detector #(
	parameter int unsigned HISTORY_DEPTH = psd_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [psd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
	psd_in_if.sink                         in_ch,
	psd_out_if.source                      out_ch
);

	psd_pkg::psd_cmd_t    cmd;
	psd_pkg::psd_status_t status;
	logic                 in_ready;

	psd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	psd_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.now_ms      (in_ch.now_ms),
		.pos_x       (in_ch.pos_x),
		.pos_y       (in_ch.pos_y),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.blocked     (out_ch.blocked),
		.sampled     (out_ch.sampled),
		.near_count  (out_ch.near_count)
	);

	assign in_ch.ready = in_ready;

endmodule

// ----- sv/psd_checker.sv -----
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the position stall detector, bound to the top level.
// ----------------------------------------------------------------------------
module psd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       blocked,
	input logic       sampled,
	input logic [3:0] near_count
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({blocked, sampled, near_count}))
		else $error("result changed while stalled");

	// one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// skipped sample reports nothing
	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sampled |-> !blocked && near_count == 4'd0)
		else $error("unsampled result carries data");

	// new result needs a prior request
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without request");

endmodule

bind position_stall_detector psd_checker u_psd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.blocked    (out_ch.blocked),
	.sampled    (out_ch.sampled),
	.near_count (out_ch.near_count)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the position stall detector. Timestamped positions
// are sent with random gaps while the result side stalls at random. A mirror
// of the history ring, the sample time and the registers predicts every
// result, and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned RING_DEPTH  = psd_pkg::HISTORY_DEPTH_DEF;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned SETTLE      = 24;
	localparam int unsigned TRACK_ITEMS = 200;
	localparam int unsigned TRACK_RUNS  = 6;
	localparam int unsigned EXP_DEPTH   = 16;

	localparam logic [psd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic signed [15:0]   POS_MIN    = 16'h8000;
	localparam logic signed [15:0]   POS_MAX    = 16'h7FFF;

	typedef struct packed {
		logic       blocked;
		logic       sampled;
		logic [3:0] near_count;
	} stall_result_t;

	typedef enum logic [1:0] {MOVE_STILL, MOVE_DRIFT, MOVE_NOISE} motion_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [psd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [psd_pkg::CFG_DATA_W-1:0] cfg_wr_data;

	psd_in_if  pos_bus ();
	psd_out_if stall_bus ();

	position_stall_detector dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (pos_bus),
		.out_ch      (stall_bus)
	);

	logic signed [15:0] ring_x [RING_DEPTH];
	logic signed [15:0] ring_y [RING_DEPTH];
	int unsigned        ring_wr;
	logic [31:0]        last_sample_ms;
	logic [15:0]        period_q;
	logic [31:0]        radius_sq_q;
	logic [3:0]         needed_q;

	stall_result_t      exp_q [EXP_DEPTH];
	int unsigned        exp_wr_cnt;
	int unsigned        exp_rd_cnt;
	stall_result_t      head_r;
	int unsigned        mismatches;
	int unsigned        cycle_cnt = 0;
	int unsigned        rx_hold_req;
	bit                 tx_steady;
	bit                 rx_steady;
	logic [31:0]        clock_ms;
	logic signed [15:0] cur_x;
	logic signed [15:0] cur_y;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic reset_mirror();
		for (int i = 0; i < RING_DEPTH; i++) begin
			ring_x[i] = '0;
			ring_y[i] = '0;
		end
		ring_wr        = 0;
		last_sample_ms = '0;
		period_q       = psd_pkg::SAMPLE_PERIOD_RST;
		radius_sq_q    = psd_pkg::NEAR_RADIUS_SQ_RST;
		needed_q       = psd_pkg::NEEDED_COUNT_RST;
	endtask

	// updates the mirrored ring and sample time as the block does
	function automatic stall_result_t predict_stall(input logic [31:0] t,
			input logic signed [15:0] x, input logic signed [15:0] y);
		logic [31:0]   delta;
		logic [31:0]   mag;
		logic [16:0]   dx;
		logic [16:0]   dy;
		logic [16:0]   ax;
		logic [16:0]   ay;
		logic [33:0]   sq;
		logic [31:0]   sq_dist;
		int unsigned   hits;
		stall_result_t res;
		res   = '0;
		hits  = 0;
		delta = t - last_sample_ms;
		mag   = delta[31] ? 32'd0 - delta : delta;
		if (mag <= {16'd0, period_q})
			return res;
		ring_x[ring_wr] = x;
		ring_y[ring_wr] = y;
		ring_wr = (ring_wr + 1) % RING_DEPTH;
		for (int i = 0; i < RING_DEPTH; i++) begin
			dx      = {x[15], x} - {ring_x[i][15], ring_x[i]};
			dy      = {y[15], y} - {ring_y[i][15], ring_y[i]};
			ax      = dx[16] ? 17'd0 - dx : dx;
			ay      = dy[16] ? 17'd0 - dy : dy;
			sq      = 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay);
			sq_dist = (sq > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sq[31:0];
			if (sq_dist < radius_sq_q)
				hits++;
		end
		res.sampled    = 1'b1;
		res.near_count = (hits > 15) ? 4'd15 : 4'(hits);
		if (hits >= needed_q) begin
			res.blocked = 1'b1;
		end else begin
			last_sample_ms = t;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch on %s: got %0d, want %0d (cycle %0d)", what, got, want,
				cycle_cnt);
	endtask

	task automatic send_pos(input logic [31:0] t, input logic signed [15:0] x,
			input logic signed [15:0] y);
		int unsigned gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap != 0) begin
			pos_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pos_bus.valid  <= 1'b1;
		pos_bus.now_ms <= t;
		pos_bus.pos_x  <= x;
		pos_bus.pos_y  <= y;
		do @(posedge clk); while (pos_bus.ready !== 1'b1);
		exp_q[exp_wr_cnt % EXP_DEPTH] = predict_stall(t, x, y);
		exp_wr_cnt++;
	endtask

	task automatic wait_idle();
		pos_bus.valid <= 1'b0;
		while (exp_wr_cnt != exp_rd_cnt) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [psd_pkg::CFG_IDX_W-1:0] idx,
			input logic [psd_pkg::CFG_DATA_W-1:0] data);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			psd_pkg::REG_SAMPLE_PERIOD:  period_q    = data[15:0];
			psd_pkg::REG_NEAR_RADIUS_SQ: radius_sq_q = data;
			psd_pkg::REG_NEEDED_COUNT:   needed_q    = data[3:0];
			default: ;
		endcase
	endtask

	// upper bits beyond the period and needed-count registers carry noise
	task automatic set_config(input logic [15:0] period, input logic [31:0] radius,
			input logic [3:0] needed);
		write_reg(psd_pkg::REG_SAMPLE_PERIOD, {16'($urandom), period});
		write_reg(psd_pkg::REG_NEAR_RADIUS_SQ, radius);
		write_reg(psd_pkg::REG_NEEDED_COUNT, {28'($urandom), needed});
	endtask

	task automatic test_reset_state();
		send_pos(32'd200, 16'sd0, 16'sd0);
		send_pos(32'd201, 16'sd0, 16'sd0);
		send_pos(32'd202, 16'sd15, 16'sd0);
		send_pos(32'd203, 16'sd16, 16'sd0);
		send_pos(last_sample_ms + 32'd200, 16'sd16, 16'sd0);
		send_pos(last_sample_ms - 32'd201, POS_MAX, POS_MIN);
		send_pos(last_sample_ms + 32'h8000_0000, POS_MIN, POS_MAX);
		send_pos(32'hFFFF_FFFF, POS_MIN, POS_MIN);
		send_pos(32'h0000_0000, POS_MAX, POS_MAX);
	endtask

	task automatic test_saturation();
		wait_idle();
		set_config(16'd0, 32'hFFFF_FFFF, 4'd1);
		send_pos(last_sample_ms + 32'd1, POS_MIN, POS_MIN);
		send_pos(last_sample_ms + 32'd1, POS_MAX, POS_MAX);
		send_pos(last_sample_ms, POS_MAX, POS_MAX);
		send_pos(last_sample_ms + 32'd7, POS_MAX, POS_MIN);
		send_pos(last_sample_ms + 32'd9, POS_MIN, POS_MAX);
	endtask

	task automatic test_count_limits();
		wait_idle();
		set_config(16'd50, 32'd0, 4'd0);
		send_pos(last_sample_ms + 32'd51, 16'sd100, -16'sd100);
		send_pos(last_sample_ms + 32'd51, 16'sd100, -16'sd100);
		wait_idle();
		set_config(16'd50, 32'hFFFF_FFFF, 4'd15);
		send_pos(last_sample_ms + 32'd51, 16'sd3, 16'sd3);
		send_pos(last_sample_ms - 32'd51, -16'sd3, 16'sd3);
		wait_idle();
		write_reg(REG_UNUSED, 32'($urandom));
		send_pos(last_sample_ms + 32'd50, 16'sd0, 16'sd0);
		send_pos(last_sample_ms + 32'd51, 16'sd0, 16'sd0);
		wait_idle();
		set_config(16'hFFFF, psd_pkg::NEAR_RADIUS_SQ_RST, psd_pkg::NEEDED_COUNT_RST);
		send_pos(last_sample_ms + 32'd65535, 16'sd0, 16'sd0);
		send_pos(last_sample_ms + 32'd65536, 16'sd0, 16'sd0);
		send_pos(last_sample_ms - 32'd65536, 16'sd16, 16'sd0);
	endtask

	task automatic test_back_pressure();
		wait_idle();
		set_config(16'd100, 32'd4096, 4'd4);
		tx_steady   = 1'b1;
		rx_hold_req = 400;
		for (int k = 0; k < 12; k++)
			send_pos(last_sample_ms + 32'd101 + 32'(k), 16'($urandom_range(0, 40)),
				16'($urandom_range(0, 40)));
		tx_steady = 1'b0;
	endtask

	task automatic run_track(input int unsigned n_items, input int unsigned jitter);
		motion_t            mode;
		int unsigned        seg_left;
		int unsigned        r;
		int                 jx;
		int                 jy;
		logic [31:0]        t;
		logic signed [15:0] px;
		logic signed [15:0] py;
		mode     = MOVE_STILL;
		seg_left = 0;
		clock_ms = last_sample_ms;
		for (int unsigned k = 0; k < n_items; k++) begin
			if (seg_left == 0) begin
				r        = $urandom_range(0, 99);
				mode     = (r < 55) ? MOVE_STILL : (r < 85) ? MOVE_DRIFT : MOVE_NOISE;
				seg_left = $urandom_range(4, 30);
				if ($urandom_range(0, 99) < 20) begin
					cur_x = 16'($urandom);
					cur_y = 16'($urandom);
				end
			end
			seg_left--;

			r = $urandom_range(0, 99);
			if (r < 60) begin
				t = clock_ms + {16'd0, period_q} + 32'd1 + $urandom_range(0, period_q / 4 + 2);
			end else if (r < 72) begin
				t = last_sample_ms + $urandom_range(0, period_q);
			end else if (r < 80) begin
				t = last_sample_ms - $urandom_range(0, period_q);
			end else if (r < 86) begin
				t = last_sample_ms + {16'd0, period_q} + $urandom_range(0, 1);
			end else if (r < 92) begin
				t = last_sample_ms - {16'd0, period_q} - $urandom_range(0, 1);
			end else begin
				t = $urandom;
			end
			clock_ms = t;

			jx = int'($urandom_range(0, 2 * jitter)) - int'(jitter);
			jy = int'($urandom_range(0, 2 * jitter)) - int'(jitter);
			case (mode)
				MOVE_STILL: begin
					px = cur_x + 16'(jx);
					py = cur_y + 16'(jy);
				end
				MOVE_DRIFT: begin
					cur_x = cur_x + 16'(2 * jx);
					cur_y = cur_y + 16'(2 * jy);
					px    = cur_x;
					py    = cur_y;
				end
				default: begin
					px = 16'($urandom);
					py = 16'($urandom);
				end
			endcase
			send_pos(t, px, py);
		end
	endtask

	task automatic test_random_tracks();
		logic [15:0] period;
		logic [31:0] radius;
		logic [3:0]  needed;
		int unsigned jitter;
		for (int ph = 0; ph < TRACK_RUNS; ph++) begin
			jitter = $urandom_range(0, 160);
			period = 16'($urandom_range(1, 600));
			radius = 32'(jitter * jitter * $urandom_range(1, 4));
			needed = 4'($urandom_range(1, 10));
			case (ph)
				0: begin
					period = psd_pkg::SAMPLE_PERIOD_RST;
					radius = psd_pkg::NEAR_RADIUS_SQ_RST;
					needed = psd_pkg::NEEDED_COUNT_RST;
					jitter = 12;
				end
				1: begin
					period = 16'd0;
					needed = 4'd1;
				end
				2: begin
					period = 16'hFFFF;
					radius = 32'hFFFF_FFFF;
				end
				5: radius = $urandom;
				default: ;
			endcase
			wait_idle();
			set_config(period, radius, needed);
			tx_steady = (ph == 3);
			rx_steady = (ph == 3);
			run_track(TRACK_ITEMS, jitter);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// result side: random stalls, plus the long hold-off on request
	initial begin : rx_side
		int unsigned hold;
		stall_bus.ready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				hold        = rx_hold_req;
				rx_hold_req = 0;
			end else if (hold == 0 && !rx_steady && $urandom_range(0, 99) < 25) begin
				hold = pick_gap();
			end
			if (hold != 0) begin
				stall_bus.ready <= 1'b0;
				hold--;
			end else begin
				stall_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && stall_bus.valid === 1'b1 && stall_bus.ready === 1'b1) begin
			if (exp_wr_cnt == exp_rd_cnt) begin
				report_mismatch("unexpected result", stall_bus.near_count, 0);
			end else begin
				head_r = exp_q[exp_rd_cnt % EXP_DEPTH];
				exp_rd_cnt++;
				if (stall_bus.blocked !== head_r.blocked)
					report_mismatch("blocked", stall_bus.blocked, head_r.blocked);
				if (stall_bus.sampled !== head_r.sampled)
					report_mismatch("sampled", stall_bus.sampled, head_r.sampled);
				if (stall_bus.near_count !== head_r.near_count)
					report_mismatch("near_count", stall_bus.near_count, head_r.near_count);
			end
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_wr_data    = '0;
		pos_bus.valid  = 1'b0;
		pos_bus.now_ms = '0;
		pos_bus.pos_x  = '0;
		pos_bus.pos_y  = '0;
		tx_steady      = 1'b0;
		rx_steady      = 1'b0;
		rx_hold_req    = 0;
		mismatches     = 0;
		exp_wr_cnt     = 0;
		exp_rd_cnt     = 0;
		cur_x          = '0;
		cur_y          = '0;
		reset_mirror();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_saturation();
		test_count_limits();
		test_back_pressure();
		test_random_tracks();

		wait_idle();
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/psd_pkg.sv
sv/psd_if.sv
sv/psd_ctrl.sv
sv/psd_datapath.sv
sv/position_stall_detector.sv
sv/psd_checker.sv
tb/sv/tb.sv
